// ----- rtl/core/gzp_pkg.sv -----
// Types and constants shared by the gaze region run packer.
// Depends on nothing; the datapath, controller, top level and bench import it.
package gzp_pkg;

   // Operation codes of a request word
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_IMAGE  = 2'd1;
   localparam logic [1:0] OP_REGION = 2'd2;

   // Result kinds
   localparam logic KIND_NEW    = 1'b0;
   localparam logic KIND_EXTEND = 1'b1;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RUN_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TUPLES       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PACKETS      = 2'd2;

   // Register reset values
   localparam logic [15:0] SC_MS         = 16'd10;
   localparam logic [7:0]  TUPLES_RESET  = 8'd20;
   localparam logic [15:0] PACKETS_RESET = 16'd1;

   localparam int REGION_BITS = 4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] gaze_x;
      logic [15:0] gaze_y;
      logic [31:0] sample_time_ms;
      logic [1:0]  region_image;
      logic [2:0]  region_slot;
      logic [15:0] left_edge;
      logic [15:0] top_edge;
      logic [15:0] right_edge;
      logic [15:0] bottom_edge;
   } req_word_type;

   typedef struct packed {
      logic                   result_kind;
      logic [REGION_BITS-1:0] region_number;
      logic [31:0]            run_start_ms;
      logic [31:0]            run_end_ms;
      logic                   packet_closed;
      logic [15:0]            packets_ready;
   } rsp_word_type;

   // Controller to datapath
   typedef struct packed {
      logic wr_region;
      logic image_pkt;
      logic latch_sample;
      logic scan_read;
      logic capture_hit;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic image_seen;
      logic hit;
      logic last;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/core/gzp_req_if.sv -----
// Request channel of the gaze region run packer: valid, ready and one word.
// Stand-alone; widths are fixed and follow the request word of gzp_pkg.
interface gzp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] gaze_x;
   logic [15:0] gaze_y;
   logic [31:0] sample_time_ms;
   logic [1:0]  region_image;
   logic [2:0]  region_slot;
   logic [15:0] left_edge;
   logic [15:0] top_edge;
   logic [15:0] right_edge;
   logic [15:0] bottom_edge;

   modport source (
      output valid, operation, gaze_x, gaze_y, sample_time_ms, region_image,
             region_slot, left_edge, top_edge, right_edge, bottom_edge,
      input  ready
   );
   modport sink (
      input  valid, operation, gaze_x, gaze_y, sample_time_ms, region_image,
             region_slot, left_edge, top_edge, right_edge, bottom_edge,
      output ready
   );
endinterface

// ----- rtl/core/gzp_rsp_if.sv -----
// Result channel of the gaze region run packer: valid, ready and one word.
// Stand-alone; widths follow the result word of gzp_pkg.
interface gzp_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [3:0]  region_number;
   logic [31:0] run_start_ms;
   logic [31:0] run_end_ms;
   logic        packet_closed;
   logic [15:0] packets_ready;

   modport source (
      output valid, result_kind, region_number, run_start_ms, run_end_ms,
             packet_closed, packets_ready,
      input  ready
   );
   modport sink (
      input  valid, result_kind, region_number, run_start_ms, run_end_ms,
             packet_closed, packets_ready,
      output ready
   );
endinterface

// ----- rtl/core/gzp_datapath.sv -----
// Datapath of the gaze region run packer: region memory, scan compare,
// run and packet state, configuration registers and the result register.
// Depends on gzp_pkg.
module gzp_datapath import gzp_pkg::*; #(
   parameter int NUM_REGIONS = 8,
   parameter int NUM_IMAGES  = 4,
   parameter int COORD_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  req_word_type              req_word,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output rsp_word_type              rsp_word
);

   localparam int DEPTH = NUM_IMAGES * NUM_REGIONS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (NUM_IMAGES > 1) ? $clog2(NUM_IMAGES) : 1;
   localparam int SW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
   localparam int CW    = $clog2(NUM_REGIONS + 1);
   localparam int EW    = 4 * COORD_BITS;

   // Region memory, one rectangle an entry: {x0, y0, x1, y1}
   logic [EW-1:0] mem [DEPTH];

   // Configuration
   logic [15:0] run_interval_ff;
   logic [7:0]  tuples_per_packet_ff;
   logic [15:0] packets_per_image_ff;

   // Image and run state
   logic [IW-1:0]          image_index_ff;
   logic                   image_seen_ff;
   logic [15:0]            image_count_ff;
   logic [REGION_BITS-1:0] open_region_ff;
   logic [31:0]            open_start_ff;
   logic [31:0]            open_end_ff;
   logic                   run_open_ff;
   logic [7:0]             tuples_ff;
   logic [15:0]            packet_total_ff;

   // Sample and scan
   logic [COORD_BITS-1:0] sample_x_ff;
   logic [COORD_BITS-1:0] sample_y_ff;
   logic [31:0]           sample_t_ff;
   logic [CW-1:0]         scan_cnt_ff;
   logic                  rd_valid_ff;
   logic [SW-1:0]         rd_slot_ff;
   logic [EW-1:0]         rd_data_ff;
   logic [SW-1:0]         hit_slot_ff;

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   logic          wr_ok;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          scan_issue;
   logic [15:0]   image_count_inc;

   logic [COORD_BITS-1:0] x0, y0, x1, y1;
   logic                  holds;

   logic [REGION_BITS-1:0] region_num;
   logic [31:0]            run_end;
   logic                   extend;
   logic [7:0]             tuples_inc;
   logic                   pkt_close;
   logic [15:0]            total_next;

   // Address the memory for writes and for the scan
   assign wr_ok   = (32'(req_word.region_image) < 32'(NUM_IMAGES)) &&
                    (32'(req_word.region_slot) < 32'(NUM_REGIONS));
   assign wr_addr = AW'(32'(req_word.region_image) * 32'(NUM_REGIONS) +
                        32'(req_word.region_slot));
   assign rd_addr = AW'(32'(image_index_ff) * 32'(NUM_REGIONS) + 32'(scan_cnt_ff));
   assign scan_issue = cmd.scan_read && (scan_cnt_ff < CW'(NUM_REGIONS));

   always_ff @(posedge clock) begin
      if (cmd.wr_region && wr_ok) begin
         mem[wr_addr] <= {req_word.left_edge[COORD_BITS-1:0],
                          req_word.top_edge[COORD_BITS-1:0],
                          req_word.right_edge[COORD_BITS-1:0],
                          req_word.bottom_edge[COORD_BITS-1:0]};
      end
      if (scan_issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Compare the registered rectangle, edges inclusive
   assign {x0, y0, x1, y1} = rd_data_ff;
   assign holds = (sample_x_ff >= x0) && (sample_x_ff <= x1) &&
                  (sample_y_ff >= y0) && (sample_y_ff <= y1);

   assign status.image_seen = image_seen_ff;
   assign status.hit        = rd_valid_ff && holds;
   assign status.last       = rd_valid_ff && (rd_slot_ff == SW'(NUM_REGIONS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign image_count_inc = image_count_ff + 16'd1;

   // Work out the run update for the matched region
   always_comb begin
      region_num = REGION_BITS'(hit_slot_ff) + REGION_BITS'(1);
      run_end    = sample_t_ff + {16'b0, run_interval_ff};
      extend     = run_open_ff && (region_num == open_region_ff) &&
                   !(sample_t_ff > open_end_ff);
      tuples_inc = tuples_ff + 8'd1;
      pkt_close  = !extend && (tuples_inc == tuples_per_packet_ff);
      total_next = (pkt_close && (packet_total_ff != 16'hFFFF)) ?
                   packet_total_ff + 16'd1 : packet_total_ff;
   end

   // Hold the sample, scan position and result word, payload only
   always_ff @(posedge clock) begin
      if (cmd.latch_sample) begin
         sample_x_ff <= req_word.gaze_x[COORD_BITS-1:0];
         sample_y_ff <= req_word.gaze_y[COORD_BITS-1:0];
         sample_t_ff <= req_word.sample_time_ms;
      end
      if (scan_issue) begin
         rd_slot_ff <= scan_cnt_ff[SW-1:0];
      end
      if (cmd.capture_hit) begin
         hit_slot_ff <= rd_slot_ff;
      end
      if (cmd.commit) begin
         rsp_word_ff.result_kind   <= extend ? KIND_EXTEND : KIND_NEW;
         rsp_word_ff.region_number <= region_num;
         rsp_word_ff.run_start_ms  <= extend ? open_start_ff : sample_t_ff;
         rsp_word_ff.run_end_ms    <= run_end;
         rsp_word_ff.packet_closed <= pkt_close;
         rsp_word_ff.packets_ready <= total_next;
      end
   end

   // Advance control state, counters and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         run_interval_ff      <= SC_MS;
         tuples_per_packet_ff <= TUPLES_RESET;
         packets_per_image_ff <= PACKETS_RESET;
         image_index_ff       <= '0;
         image_seen_ff        <= 1'b0;
         image_count_ff       <= '0;
         open_region_ff       <= '0;
         open_start_ff        <= '0;
         open_end_ff          <= '0;
         run_open_ff          <= 1'b0;
         tuples_ff            <= '0;
         packet_total_ff      <= '0;
         scan_cnt_ff          <= '0;
         rd_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RUN_INTERVAL: run_interval_ff      <= csr_write_data;
               CSR_TUPLES:       tuples_per_packet_ff <= csr_write_data[7:0];
               CSR_PACKETS:      packets_per_image_ff <= csr_write_data;
               default:          ;
            endcase
         end

         // Count image packets and move to the next image slot
         if (cmd.image_pkt) begin
            if (image_count_inc == packets_per_image_ff) begin
               image_count_ff <= '0;
               image_seen_ff  <= 1'b1;
               image_index_ff <= (image_index_ff == IW'(NUM_IMAGES - 1)) ?
                                 '0 : image_index_ff + IW'(1);
            end else begin
               image_count_ff <= image_count_inc;
            end
         end

         if (cmd.latch_sample) begin
            scan_cnt_ff <= '0;
         end else if (scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + CW'(1);
         end
         rd_valid_ff <= scan_issue;

         // Open, extend or close the run
         if (cmd.commit) begin
            open_end_ff <= run_end;
            if (!extend) begin
               open_region_ff  <= region_num;
               open_start_ff   <= sample_t_ff;
               run_open_ff     <= !pkt_close;
               tuples_ff       <= pkt_close ? 8'd0 : tuples_inc;
               packet_total_ff <= total_next;
            end
         end

         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_commit_shows_word: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed word not presented");

   a_closed_is_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.packet_closed |-> rsp_word_ff.result_kind == KIND_NEW)
      else $error("extension word marked as closing a packet");

   a_extend_region: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_word_ff.result_kind == KIND_EXTEND) |->
         rsp_word_ff.region_number == open_region_ff)
      else $error("extension word region differs from open run");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> packet_total_ff >= $past(packet_total_ff))
      else $error("packet total went backwards");

endmodule

// ----- rtl/core/gzp_controller.sv -----
// Controller of the gaze region run packer: takes request words, steps the
// region scan and commits results. Depends on gzp_pkg.
module gzp_controller import gzp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      accept;

   assign accept = req_valid && req_ready_ff;

   // Decode the word or the scan step into commands
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_REGION: cmd.wr_region = 1'b1;
                  OP_IMAGE:  cmd.image_pkt = 1'b1;
                  OP_SAMPLE: begin
                     // drop samples before the first full image
                     if (status.image_seen) begin
                        cmd.latch_sample = 1'b1;
                        state_in         = ST_SCAN;
                        req_ready_in     = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.hit) begin
               cmd.capture_hit = 1'b1;
               state_in        = ST_COMMIT;
            end else if (status.last) begin
               state_in     = ST_IDLE;
               req_ready_in = 1'b1;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit   = 1'b1;
               state_in     = ST_IDLE;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
         end
      endcase
   end

   // Hold state and the ready flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready_ff)
      else $error("ready raised while a sample is in progress");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("result committed over an untaken word");

endmodule

// ----- rtl/core/gaze_region_run_packer.sv -----
// Top level of the gaze region run packer: controller plus datapath.
// Depends on gzp_pkg, gzp_req_if, gzp_rsp_if, gzp_controller, gzp_datapath.
//
//   channel   direction  handshake        word
//   req_chan  in         valid/ready      operation, sample, region write
//   rsp_chan  out        valid/ready      run tuple or run extension
//   csr_*     in         write enable     register index and data
//
// A region write or an image packet is taken from idle. A gaze sample scans
// the region slots of the current image in order and commits on the first
// match, or goes back to idle with no match; the region memory read port
// gives one rectangle a cycle. Reset is synchronous and clears all control
// state; the region memory is not cleared. A result waits in the output
// register while writes and image packets still go in; a matched sample
// holds in commit until that register is free.
module gaze_region_run_packer import gzp_pkg::*; #(
   parameter int NUM_REGIONS = 8,
   parameter int NUM_IMAGES  = 4,
   parameter int COORD_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   gzp_req_if.sink                   req_chan,
   gzp_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cmd_type      cmd;
   status_type   status;
   req_word_type req_word;
   rsp_word_type rsp_word;
   logic         req_ready;
   logic         rsp_valid;

   // Gather the request word
   assign req_word.operation      = req_chan.operation;
   assign req_word.gaze_x         = req_chan.gaze_x;
   assign req_word.gaze_y         = req_chan.gaze_y;
   assign req_word.sample_time_ms = req_chan.sample_time_ms;
   assign req_word.region_image   = req_chan.region_image;
   assign req_word.region_slot    = req_chan.region_slot;
   assign req_word.left_edge      = req_chan.left_edge;
   assign req_word.top_edge       = req_chan.top_edge;
   assign req_word.right_edge     = req_chan.right_edge;
   assign req_word.bottom_edge    = req_chan.bottom_edge;
   assign req_chan.ready          = req_ready;

   gzp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gzp_datapath #(
      .NUM_REGIONS (NUM_REGIONS),
      .NUM_IMAGES  (NUM_IMAGES),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_word         (req_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_valid),
      .rsp_word         (rsp_word)
   );

   // Drive the result word
   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.result_kind   = rsp_word.result_kind;
   assign rsp_chan.region_number = rsp_word.region_number;
   assign rsp_chan.run_start_ms  = rsp_word.run_start_ms;
   assign rsp_chan.run_end_ms    = rsp_word.run_end_ms;
   assign rsp_chan.packet_closed = rsp_word.packet_closed;
   assign rsp_chan.packets_ready = rsp_word.packets_ready;

endmodule

// ----- tb/sv/gaze_region_run_packer_test.sv -----
// Self-checking bench for the gaze region run packer: a queue-fed word driver,
// a result monitor and a run and packet predictor of its own.
// Depends on gzp_pkg, gzp_req_if, gzp_rsp_if and gaze_region_run_packer.
module gaze_region_run_packer_test;
   import gzp_pkg::*;

   localparam int NUM_REGIONS   = 8;
   localparam int NUM_IMAGES    = 4;
   localparam int COORD_BITS    = 16;
   localparam int MAX_IDLE      = 17;
   localparam int SETTLE_CYCLES = 2 * NUM_REGIONS + 8;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int PHASES        = 8;
   localparam int TABLE_DEPTH   = NUM_IMAGES * NUM_REGIONS;

   localparam logic [1:0]                OP_NONE   = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
   } box_type;

   localparam box_type NO_BOX   = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
   localparam box_type FULL_BOX = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   gzp_req_if req_chan ();
   gzp_rsp_if rsp_chan ();

   gaze_region_run_packer #(
      .NUM_REGIONS(NUM_REGIONS),
      .NUM_IMAGES (NUM_IMAGES),
      .COORD_BITS (COORD_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state and register copies
   box_type     region_boxes [TABLE_DEPTH];
   logic [1:0]  shown_image;
   logic        image_shown;
   logic [15:0] image_pkt_count;
   logic [3:0]  run_region;
   logic [31:0] run_start;
   logic [31:0] run_end;
   logic        run_live;
   logic [7:0]  tuple_fill;
   logic [15:0] packets_done;
   logic [15:0] cfg_interval;
   logic [7:0]  cfg_tuples;
   logic [15:0] cfg_packets;

   // Stimulus bookkeeping: what the table and image slot will be once queued words land
   box_type     planned_boxes [TABLE_DEPTH];
   logic [1:0]  planned_image;
   logic [15:0] planned_pkts;
   logic [31:0] gaze_clock;
   int          aim_slot;

   req_word_type words_pending [$];
   rsp_word_type runs_expected [$];
   int           mismatch_count = 0;
   bit           sender_idles = 1'b0;
   bit           receiver_idles = 1'b0;
   int           hold_req = 0;
   int           hold_rsp = 0;

   // Advance the run and packet state by one accepted word; report a result if any
   function automatic bit predict_run(input req_word_type w, output rsp_word_type run);
      logic [3:0]  hit;
      logic [31:0] limit;
      box_type     b;
      run = '0;
      hit = '0;
      case (w.operation)
         OP_REGION: begin
            region_boxes[w.region_image * NUM_REGIONS + w.region_slot] =
               {w.left_edge, w.top_edge, w.right_edge, w.bottom_edge};
         end
         OP_IMAGE: begin
            image_pkt_count = image_pkt_count + 16'd1;
            if (image_pkt_count == cfg_packets) begin
               shown_image     = shown_image + 2'd1;
               image_pkt_count = '0;
               image_shown     = 1'b1;
            end
         end
         OP_SAMPLE: begin
            if (image_shown) begin
               // scan from the top so the lowest matching slot wins
               for (int k = NUM_REGIONS - 1; k >= 0; k--) begin
                  b = region_boxes[shown_image * NUM_REGIONS + k];
                  if (w.gaze_x >= b.left && w.gaze_x <= b.right &&
                      w.gaze_y >= b.top && w.gaze_y <= b.bottom) begin
                     hit = 4'(k + 1);
                  end
               end
            end
            if (hit != '0) begin
               limit = w.sample_time_ms + 32'(cfg_interval);
               if (run_live && hit == run_region && w.sample_time_ms <= run_end) begin
                  run_end         = limit;
                  run.result_kind = KIND_EXTEND;
               end else begin
                  run_region      = hit;
                  run_start       = w.sample_time_ms;
                  run_end         = limit;
                  run_live        = 1'b1;
                  run.result_kind = KIND_NEW;
                  tuple_fill      = tuple_fill + 8'd1;
                  if (tuple_fill == cfg_tuples) begin
                     if (packets_done != 16'hFFFF) begin
                        packets_done = packets_done + 16'd1;
                     end
                     tuple_fill        = '0;
                     run_live          = 1'b0;
                     run.packet_closed = 1'b1;
                  end
               end
               run.region_number = hit;
               run.run_start_ms  = run_start;
               run.run_end_ms    = run_end;
               run.packets_ready = packets_done;
            end
         end
         default: ;
      endcase
      return hit != '0;
   endfunction

   function automatic req_word_type noise_word(input logic [1:0] op);
      req_word_type w;
      w.operation      = op;
      w.gaze_x         = 16'($urandom);
      w.gaze_y         = 16'($urandom);
      w.sample_time_ms = $urandom;
      w.region_image   = 2'($urandom);
      w.region_slot    = 3'($urandom);
      w.left_edge      = 16'($urandom);
      w.top_edge       = 16'($urandom);
      w.right_edge     = 16'($urandom);
      w.bottom_edge    = 16'($urandom);
      return w;
   endfunction

   function automatic req_word_type rect_word(input logic [1:0] img, input logic [2:0] slot,
                                              input box_type b);
      req_word_type w;
      w              = noise_word(OP_REGION);
      w.region_image = img;
      w.region_slot  = slot;
      w.left_edge    = b.left;
      w.top_edge     = b.top;
      w.right_edge   = b.right;
      w.bottom_edge  = b.bottom;
      return w;
   endfunction

   function automatic req_word_type sample_word(input logic [15:0] x, input logic [15:0] y,
                                                input logic [31:0] t);
      req_word_type w;
      w                = noise_word(OP_SAMPLE);
      w.gaze_x         = x;
      w.gaze_y         = y;
      w.sample_time_ms = t;
      return w;
   endfunction

   function automatic logic [15:0] pick_between(input logic [15:0] lo, input logic [15:0] hi);
      return 16'($urandom_range(hi, lo));
   endfunction

   // Queue a word and keep the planned table and image slot in step
   task automatic queue_word(input req_word_type w);
      if (w.operation == OP_REGION) begin
         planned_boxes[w.region_image * NUM_REGIONS + w.region_slot] =
            {w.left_edge, w.top_edge, w.right_edge, w.bottom_edge};
      end else if (w.operation == OP_IMAGE) begin
         planned_pkts = planned_pkts + 16'd1;
         if (planned_pkts == cfg_packets) begin
            planned_image = planned_image + 2'd1;
            planned_pkts  = '0;
         end
      end
      words_pending.insert(words_pending.size(), w);
   endtask

   // One register write, only ever issued while the block is idle
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_RUN_INTERVAL: cfg_interval = data;
         CSR_TUPLES:       cfg_tuples   = data[7:0];
         CSR_PACKETS:      cfg_packets  = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Hold until every word is taken and every run has come back, then let the block settle
   task automatic wait_drained();
      while (words_pending.size() != 0 || runs_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic offer_word(input req_word_type w);
      req_chan.valid          <= 1'b1;
      req_chan.operation      <= w.operation;
      req_chan.gaze_x         <= w.gaze_x;
      req_chan.gaze_y         <= w.gaze_y;
      req_chan.sample_time_ms <= w.sample_time_ms;
      req_chan.region_image   <= w.region_image;
      req_chan.region_slot    <= w.region_slot;
      req_chan.left_edge      <= w.left_edge;
      req_chan.top_edge       <= w.top_edge;
      req_chan.right_edge     <= w.right_edge;
      req_chan.bottom_edge    <= w.bottom_edge;
   endtask

   // Driver: present the oldest pending word, predict on acceptance, then idle a while when sender idles are on
   always @(posedge clock) begin : drive_words
      rsp_word_type run;
      int           gap;
      if (reset) begin
         req_chan.valid <= 1'b0;
         hold_req       <= 0;
      end else if (req_chan.valid && req_chan.ready) begin
         if (predict_run(words_pending[0], run)) begin
            runs_expected.insert(runs_expected.size(), run);
         end
         void'(words_pending.pop_front());
         gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
         if (gap == 0 && words_pending.size() != 0) begin
            offer_word(words_pending[0]);
         end else begin
            req_chan.valid <= 1'b0;
            hold_req       <= (gap == 0) ? 0 : gap - 1;
         end
      end else if (!req_chan.valid) begin
         if (hold_req != 0) begin
            hold_req <= hold_req - 1;
         end else if (words_pending.size() != 0) begin
            offer_word(words_pending[0]);
         end
      end
   end

   // Monitor: check each result word against the oldest expected run, then stall a while when receiver idles are on
   always @(posedge clock) begin : watch_runs
      rsp_word_type want;
      int           stall;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_rsp       <= 0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         if (runs_expected.size() == 0) begin
            $error("result word arrived with no run expected");
            mismatch_count = mismatch_count + 1;
         end else begin
            want = runs_expected.pop_front();
            if (rsp_chan.result_kind !== want.result_kind) begin
               $error("result_kind: expected %0d, got %0d", want.result_kind,
                      rsp_chan.result_kind);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_chan.region_number !== want.region_number) begin
               $error("region_number: expected %0d, got %0d", want.region_number,
                      rsp_chan.region_number);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_chan.run_start_ms !== want.run_start_ms) begin
               $error("run_start_ms: expected %0d, got %0d", want.run_start_ms,
                      rsp_chan.run_start_ms);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_chan.run_end_ms !== want.run_end_ms) begin
               $error("run_end_ms: expected %0d, got %0d", want.run_end_ms,
                      rsp_chan.run_end_ms);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_chan.packet_closed !== want.packet_closed) begin
               $error("packet_closed: expected %0d, got %0d", want.packet_closed,
                      rsp_chan.packet_closed);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_chan.packets_ready !== want.packets_ready) begin
               $error("packets_ready: expected %0d, got %0d", want.packets_ready,
                      rsp_chan.packets_ready);
               mismatch_count = mismatch_count + 1;
            end
         end
         stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_rsp       <= stall - 1;
         end
      end else if (!rsp_chan.ready) begin
         if (hold_rsp != 0) begin
            hold_rsp <= hold_rsp - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      box_type                  b;
      logic [15:0]              x;
      logic [15:0]              y;
      logic [1:0]               img;
      int                       roll;
      int                       n_items;
      logic [CSR_DATA_BITS-1:0] set_interval;
      logic [CSR_DATA_BITS-1:0] set_tuples;
      logic [CSR_DATA_BITS-1:0] set_packets;

      // Known values on every input from time zero
      req_chan.valid = 1'b0;
      {req_chan.operation, req_chan.gaze_x, req_chan.gaze_y, req_chan.sample_time_ms,
       req_chan.region_image, req_chan.region_slot, req_chan.left_edge, req_chan.top_edge,
       req_chan.right_edge, req_chan.bottom_edge} = '0;
      rsp_chan.ready = 1'b0;

      // Mirror the reset state
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         region_boxes[i]  = '0;
         planned_boxes[i] = '0;
      end
      shown_image     = '0;
      image_shown     = 1'b0;
      image_pkt_count = '0;
      run_region      = '0;
      run_start       = '0;
      run_end         = '0;
      run_live        = 1'b0;
      tuple_fill      = '0;
      packets_done    = '0;
      cfg_interval    = SC_MS;
      cfg_tuples      = TUPLES_RESET;
      cfg_packets     = PACKETS_RESET;
      planned_image   = '0;
      planned_pkts    = '0;
      gaze_clock      = '0;
      aim_slot        = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole table with empty rectangles so no scan reads an unwritten entry
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         queue_word(rect_word(2'(i / NUM_REGIONS), 3'(i % NUM_REGIONS), NO_BOX));
      end

      // Directed: dropped words, inclusive edges, extension, region change, time wrap
      queue_word(noise_word(OP_NONE));
      queue_word(sample_word(16'd150, 16'd300, 32'd5));
      queue_word(rect_word(2'd1, 3'd0, '{16'd100, 16'd200, 16'd300, 16'd400}));
      queue_word(noise_word(OP_IMAGE));
      queue_word(sample_word(16'd99, 16'd300, 32'd0));
      queue_word(sample_word(16'd100, 16'd200, 32'd0));
      queue_word(sample_word(16'd300, 16'd400, 32'd10));
      queue_word(rect_word(2'd1, 3'd1, FULL_BOX));
      queue_word(sample_word(16'd301, 16'd400, 32'd15));
      queue_word(sample_word(16'hFFFF, 16'hFFFF, 32'd25));
      queue_word(sample_word(16'd0, 16'd0, 32'd36));
      queue_word(sample_word(16'd200, 16'd300, 32'd36));
      queue_word(sample_word(16'd200, 16'd300, 32'hFFFF_FFFA));
      queue_word(sample_word(16'd200, 16'd300, 32'hFFFF_FFFF));
      queue_word(sample_word(16'd200, 16'd300, 32'h0000_0002));
      queue_word(noise_word(OP_NONE));
      queue_word(rect_word(2'd3, 3'd7, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}));
      queue_word(rect_word(2'd0, 3'd0, '0));
      gaze_clock = 32'h0000_0100;
      wait_drained();

      for (int phase = 1; phase <= PHASES; phase++) begin
         sender_idles   = phase[0];
         receiver_idles = phase[1];
         case (phase)
            1: begin
               set_interval = 16'd1;     set_tuples = 16'd1;     set_packets = 16'd1;
               n_items = 100;
            end
            2: begin
               set_interval = 16'hFFFF;  set_tuples = 16'd255;   set_packets = 16'd2;
               n_items = 120;
            end
            3: begin
               // upper bits drop, leaving a zero tuple count
               set_interval = 16'd3;     set_tuples = 16'hFF00;  set_packets = 16'd1;
               n_items = 260;
            end
            7: begin
               set_interval = 16'($urandom_range(1, 100));
               set_tuples = 16'hAB03;    set_packets = 16'd0;
               n_items = 100;
            end
            8: begin
               set_interval = 16'd200;   set_tuples = 16'd7;     set_packets = 16'hFFFF;
               n_items = 100;
            end
            default: begin
               set_interval = 16'($urandom_range(1, 500));
               set_tuples   = 16'($urandom_range(1, 30));
               set_packets  = 16'($urandom_range(1, 3));
               n_items = 130;
            end
         endcase
         write_csr(CSR_RUN_INTERVAL, set_interval);
         write_csr(CSR_TUPLES, set_tuples);
         write_csr(CSR_PACKETS, set_packets);
         if (phase == 7) begin
            write_csr(CSR_SPARE, 16'hFFFF);
         end

         for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 62) begin
               // well-formed sample: mostly the same slot, near the running clock
               if ($urandom_range(0, 9) < 3) begin
                  aim_slot = $urandom_range(0, NUM_REGIONS - 1);
               end
               b = planned_boxes[planned_image * NUM_REGIONS + aim_slot];
               case ($urandom_range(0, 7))
                  0: begin
                     x = b.left;
                     y = b.top;
                  end
                  1: begin
                     x = b.right;
                     y = b.bottom;
                  end
                  default: begin
                     x = pick_between(b.left, b.right);
                     y = pick_between(b.top, b.bottom);
                  end
               endcase
               if (b.left > b.right || b.top > b.bottom) begin
                  x = 16'($urandom);
                  y = 16'($urandom);
               end
               if ($urandom_range(0, 49) == 0) begin
                  gaze_clock = $urandom;
               end else if ($urandom_range(0, 49) == 0) begin
                  gaze_clock = 32'hFFFF_FFFF - $urandom_range(0, 2 * cfg_interval);
               end else begin
                  gaze_clock = gaze_clock + $urandom_range(0, 2 * cfg_interval + 2);
               end
               queue_word(sample_word(x, y, gaze_clock));
            end else if (roll < 70) begin
               queue_word(noise_word(OP_SAMPLE));
            end else if (roll < 84) begin
               case ($urandom_range(0, 9))
                  0: b = FULL_BOX;
                  1: begin
                     b.left   = 16'($urandom);
                     b.top    = 16'($urandom);
                     b.right  = 16'($urandom);
                     b.bottom = 16'($urandom);
                  end
                  default: begin
                     b.left   = 16'($urandom);
                     b.top    = 16'($urandom);
                     b.right  = b.left + 16'($urandom_range(0, 12000));
                     b.bottom = b.top + 16'($urandom_range(0, 12000));
                  end
               endcase
               // aim writes mostly at the image in use and the one after it
               case ($urandom_range(0, 3))
                  0, 1: img = planned_image;
                  2:    img = planned_image + 2'd1;
                  default: img = 2'($urandom);
               endcase
               queue_word(rect_word(img, 3'($urandom_range(0, NUM_REGIONS - 1)), b));
            end else if (roll < 94) begin
               queue_word(noise_word(OP_IMAGE));
            end else begin
               queue_word(noise_word(OP_NONE));
            end
         end

         // Complete a part-counted image, for a packet setting of one to three, so the next setting starts from zero
         if (cfg_packets != 0 && cfg_packets <= 16'd3) begin
            while (planned_pkts != 0) begin
               queue_word(noise_word(OP_IMAGE));
            end
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #(2 * LIMIT_CYCLES);
      $display("FAILURE");
      $finish;
   end

endmodule
